/* sv/s5hs_pkg.sv */
// shared types and constants for the socks5 handshake parser
package s5hs_pkg;

   localparam logic [7:0] SocksVer   = 8'd5;
   localparam logic [7:0] CmdConnect = 8'd1;
   localparam logic [7:0] AtypIpv4   = 8'd1;
   localparam logic [7:0] AtypName   = 8'd3;
   localparam logic [7:0] MethNoAuth = 8'd0;

   typedef enum logic [2:0] {
      EV_AUTH_OK   = 3'd0,
      EV_AUTH_REJ  = 3'd1,
      EV_BAD_GREET = 3'd2,
      EV_BAD_REQ   = 3'd3,
      EV_BAD_ATYP  = 3'd4,
      EV_IPV4_DONE = 3'd5,
      EV_NAME_CHAR = 3'd6,
      EV_NAME_DONE = 3'd7
   } event_type;

   typedef enum logic [12:0] {
      PH_GVER  = 13'b0000000000001,
      PH_GNUM  = 13'b0000000000010,
      PH_GMETH = 13'b0000000000100,
      PH_RVER  = 13'b0000000001000,
      PH_RCMD  = 13'b0000000010000,
      PH_RRSV  = 13'b0000000100000,
      PH_RATYP = 13'b0000001000000,
      PH_IPV4  = 13'b0000010000000,
      PH_IPORT = 13'b0000100000000,
      PH_NLEN  = 13'b0001000000000,
      PH_NAME  = 13'b0010000000000,
      PH_NPORT = 13'b0100000000000,
      PH_IDLE  = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_conn;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_code;
      logic [31:0] ipv4_address;
      logic [15:0] dest_port;
      logic [7:0]  name_char;
      logic [7:0]  name_length;
   } rsp_type;

endpackage

/* sv/s5hs_parser.sv */
// byte-wise protocol state machine: greeting, request and address parsing
module s5hs_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  s5hs_pkg::req_type req,
   output logic              ev_valid,
   output s5hs_pkg::rsp_type ev
);

   s5hs_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  methods_left_ff, methods_left_in;
   logic        noauth_seen_ff, noauth_seen_in;
   logic [31:0] address_acc_ff, address_acc_in;
   logic [15:0] port_acc_ff, port_acc_in;
   logic [7:0]  name_len_ff, name_len_in;
   logic [7:0]  b;
   logic [7:0]  idx_inc;
   logic [7:0]  meth_dec;
   logic        noauth_now;

   assign b          = req.data_byte;
   assign idx_inc    = byte_index_ff + 8'd1;
   assign meth_dec   = methods_left_ff - 8'd1;
   assign noauth_now = noauth_seen_ff | (b == s5hs_pkg::MethNoAuth);
   // the other fields are always rewritten before use, so start only moves the phase
   assign phase_cur  = req.start_conn ? s5hs_pkg::PH_GVER : phase_ff;

   always_comb begin
      phase_in        = phase_ff;
      byte_index_in   = byte_index_ff;
      methods_left_in = methods_left_ff;
      noauth_seen_in  = noauth_seen_ff;
      address_acc_in  = address_acc_ff;
      port_acc_in     = port_acc_ff;
      name_len_in     = name_len_ff;
      ev_valid        = 1'b0;
      ev              = '0;
      if (accept) begin
         phase_in = phase_cur;
         unique case (phase_cur)
            s5hs_pkg::PH_GVER: begin
               if (b != s5hs_pkg::SocksVer) begin
                  phase_in      = s5hs_pkg::PH_IDLE;
                  ev_valid      = 1'b1;
                  ev.event_code = s5hs_pkg::EV_BAD_GREET;
               end else begin
                  phase_in = s5hs_pkg::PH_GNUM;
               end
            end
            s5hs_pkg::PH_GNUM: begin
               methods_left_in = b;
               noauth_seen_in  = 1'b0;
               if (b == 8'd0) begin
                  phase_in      = s5hs_pkg::PH_IDLE;
                  ev_valid      = 1'b1;
                  ev.event_code = s5hs_pkg::EV_AUTH_REJ;
               end else begin
                  phase_in = s5hs_pkg::PH_GMETH;
               end
            end
            s5hs_pkg::PH_GMETH: begin
               noauth_seen_in  = noauth_now;
               methods_left_in = meth_dec;
               if (meth_dec == 8'd0) begin
                  ev_valid = 1'b1;
                  if (noauth_now) begin
                     phase_in      = s5hs_pkg::PH_RVER;
                     ev.event_code = s5hs_pkg::EV_AUTH_OK;
                  end else begin
                     phase_in      = s5hs_pkg::PH_IDLE;
                     ev.event_code = s5hs_pkg::EV_AUTH_REJ;
                  end
               end
            end
            s5hs_pkg::PH_RVER: begin
               if (b != s5hs_pkg::SocksVer) begin
                  phase_in      = s5hs_pkg::PH_IDLE;
                  ev_valid      = 1'b1;
                  ev.event_code = s5hs_pkg::EV_BAD_REQ;
               end else begin
                  phase_in = s5hs_pkg::PH_RCMD;
               end
            end
            s5hs_pkg::PH_RCMD: begin
               if (b != s5hs_pkg::CmdConnect) begin
                  phase_in      = s5hs_pkg::PH_IDLE;
                  ev_valid      = 1'b1;
                  ev.event_code = s5hs_pkg::EV_BAD_REQ;
               end else begin
                  phase_in = s5hs_pkg::PH_RRSV;
               end
            end
            s5hs_pkg::PH_RRSV: begin
               phase_in = s5hs_pkg::PH_RATYP;
            end
            s5hs_pkg::PH_RATYP: begin
               byte_index_in  = 8'd0;
               address_acc_in = 32'd0;
               port_acc_in    = 16'd0;
               if (b == s5hs_pkg::AtypIpv4) begin
                  phase_in = s5hs_pkg::PH_IPV4;
               end else if (b == s5hs_pkg::AtypName) begin
                  phase_in = s5hs_pkg::PH_NLEN;
               end else begin
                  phase_in      = s5hs_pkg::PH_IDLE;
                  ev_valid      = 1'b1;
                  ev.event_code = s5hs_pkg::EV_BAD_ATYP;
               end
            end
            s5hs_pkg::PH_IPV4: begin
               address_acc_in = {address_acc_ff[23:0], b};
               if (idx_inc >= 8'd4) begin
                  byte_index_in = 8'd0;
                  phase_in      = s5hs_pkg::PH_IPORT;
               end else begin
                  byte_index_in = idx_inc;
               end
            end
            s5hs_pkg::PH_NLEN: begin
               name_len_in   = b;
               byte_index_in = 8'd0;
               phase_in      = (b == 8'd0) ? s5hs_pkg::PH_NPORT : s5hs_pkg::PH_NAME;
            end
            s5hs_pkg::PH_NAME: begin
               if (idx_inc >= name_len_ff) begin
                  byte_index_in = 8'd0;
                  phase_in      = s5hs_pkg::PH_NPORT;
               end else begin
                  byte_index_in = idx_inc;
               end
               ev_valid      = 1'b1;
               ev.event_code = s5hs_pkg::EV_NAME_CHAR;
               ev.name_char  = b;
            end
            s5hs_pkg::PH_IPORT, s5hs_pkg::PH_NPORT: begin
               port_acc_in = {port_acc_ff[7:0], b};
               if (idx_inc < 8'd2) begin
                  byte_index_in = idx_inc;
               end else begin
                  byte_index_in = 8'd0;
                  phase_in      = s5hs_pkg::PH_IDLE;
                  ev_valid      = 1'b1;
                  ev.dest_port  = {port_acc_ff[7:0], b};
                  if (phase_cur == s5hs_pkg::PH_IPORT) begin
                     ev.event_code   = s5hs_pkg::EV_IPV4_DONE;
                     ev.ipv4_address = address_acc_ff;
                  end else begin
                     ev.event_code  = s5hs_pkg::EV_NAME_DONE;
                     ev.name_length = name_len_ff;
                  end
               end
            end
            default: begin
               phase_in = s5hs_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= s5hs_pkg::PH_GVER;
         byte_index_ff   <= 8'd0;
         methods_left_ff <= 8'd0;
         noauth_seen_ff  <= 1'b0;
         address_acc_ff  <= 32'd0;
         port_acc_ff     <= 16'd0;
         name_len_ff     <= 8'd0;
      end else begin
         phase_ff        <= phase_in;
         byte_index_ff   <= byte_index_in;
         methods_left_ff <= methods_left_in;
         noauth_seen_ff  <= noauth_seen_in;
         address_acc_ff  <= address_acc_in;
         port_acc_ff     <= port_acc_in;
         name_len_ff     <= name_len_in;
      end
   end

endmodule

/* sv/s5hs_out_buf.sv */
// result register with a skid entry so input flows on while one result stalls
module s5hs_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  s5hs_pkg::rsp_type push_data,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output s5hs_pkg::rsp_type rsp_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   s5hs_pkg::rsp_type main_ff, main_in;
   s5hs_pkg::rsp_type skid_ff, skid_in;

   assign space     = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            // push is held off while the skid entry is full
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

/* sv/socks5_handshake_parser.sv */
// top level: socks5 greeting and connect request parser, one client byte per transfer
// each result is registered in the main entry, via the skid entry under output stall
// throughput: one byte per cycle while req_ready is high, set by the phase state machine
// a two-entry result buffer keeps req_ready high while one result waits on rsp_ready
// reset: synchronous, puts the parser in the greeting version phase and empties the buffer
module socks5_handshake_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  s5hs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output s5hs_pkg::rsp_type rsp_data
);

   logic              accept;
   logic              ev_valid;
   logic              space;
   s5hs_pkg::rsp_type ev;

   assign req_ready = space;
   assign accept    = req_valid && space;

   s5hs_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .ev_valid (ev_valid),
      .ev       (ev)
   );

   s5hs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_valid),
      .push_data (ev),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/s5hs_result_checker.sv */
// result checker for the socks5 handshake parser: predicts events and compares transfers
`timescale 1ns / 1ps

module s5hs_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  s5hs_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  s5hs_pkg::rsp_type rsp_data,
   output int                fail_total,
   output int                pending_results
);

   s5hs_pkg::phase_type parse_phase;
   logic [7:0]          byte_idx;
   logic [7:0]          methods_left;
   logic                noauth_seen;
   logic [31:0]         addr_acc;
   logic [15:0]         port_acc;
   logic [7:0]          name_len;

   s5hs_pkg::rsp_type   expected_events[$];
   s5hs_pkg::rsp_type   next_event;
   s5hs_pkg::rsp_type   want;
   int                  mismatches = 0;

   task automatic report_mismatch(input string what, input int unsigned want_val,
                                  input int unsigned seen_val);
      $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want_val, seen_val);
      mismatches++;
   endtask

   function automatic void clear_parser();
      parse_phase  = s5hs_pkg::PH_GVER;
      byte_idx     = '0;
      methods_left = '0;
      noauth_seen  = 1'b0;
      addr_acc     = '0;
      port_acc     = '0;
      name_len     = '0;
   endfunction

   // advances the parser by one client byte, returns 1 when an event comes out
   function automatic bit parse_byte(input s5hs_pkg::req_type item,
                                     output s5hs_pkg::rsp_type res);
      logic [7:0] b;
      bit         hit;
      b   = item.data_byte;
      res = '0;
      hit = 1'b0;
      if (item.start_conn) clear_parser();
      case (parse_phase)
         s5hs_pkg::PH_GVER: begin
            if (b != s5hs_pkg::SocksVer) begin
               parse_phase = s5hs_pkg::PH_IDLE;
               res.event_code = s5hs_pkg::EV_BAD_GREET;
               hit = 1'b1;
            end else begin
               parse_phase = s5hs_pkg::PH_GNUM;
            end
         end
         s5hs_pkg::PH_GNUM: begin
            methods_left = b;
            noauth_seen  = 1'b0;
            if (b == 8'd0) begin
               parse_phase = s5hs_pkg::PH_IDLE;
               res.event_code = s5hs_pkg::EV_AUTH_REJ;
               hit = 1'b1;
            end else begin
               parse_phase = s5hs_pkg::PH_GMETH;
            end
         end
         s5hs_pkg::PH_GMETH: begin
            if (b == s5hs_pkg::MethNoAuth) noauth_seen = 1'b1;
            methods_left = methods_left - 8'd1;
            if (methods_left == 8'd0) begin
               hit = 1'b1;
               if (noauth_seen) begin
                  parse_phase = s5hs_pkg::PH_RVER;
                  res.event_code = s5hs_pkg::EV_AUTH_OK;
               end else begin
                  parse_phase = s5hs_pkg::PH_IDLE;
                  res.event_code = s5hs_pkg::EV_AUTH_REJ;
               end
            end
         end
         s5hs_pkg::PH_RVER: begin
            if (b != s5hs_pkg::SocksVer) begin
               parse_phase = s5hs_pkg::PH_IDLE;
               res.event_code = s5hs_pkg::EV_BAD_REQ;
               hit = 1'b1;
            end else begin
               parse_phase = s5hs_pkg::PH_RCMD;
            end
         end
         s5hs_pkg::PH_RCMD: begin
            if (b != s5hs_pkg::CmdConnect) begin
               parse_phase = s5hs_pkg::PH_IDLE;
               res.event_code = s5hs_pkg::EV_BAD_REQ;
               hit = 1'b1;
            end else begin
               parse_phase = s5hs_pkg::PH_RRSV;
            end
         end
         s5hs_pkg::PH_RRSV: begin
            parse_phase = s5hs_pkg::PH_RATYP;
         end
         s5hs_pkg::PH_RATYP: begin
            byte_idx = '0;
            addr_acc = '0;
            port_acc = '0;
            if (b == s5hs_pkg::AtypIpv4) begin
               parse_phase = s5hs_pkg::PH_IPV4;
            end else if (b == s5hs_pkg::AtypName) begin
               parse_phase = s5hs_pkg::PH_NLEN;
            end else begin
               parse_phase = s5hs_pkg::PH_IDLE;
               res.event_code = s5hs_pkg::EV_BAD_ATYP;
               hit = 1'b1;
            end
         end
         s5hs_pkg::PH_IPV4: begin
            addr_acc = {addr_acc[23:0], b};
            byte_idx = byte_idx + 8'd1;
            if (byte_idx >= 8'd4) begin
               byte_idx = '0;
               parse_phase = s5hs_pkg::PH_IPORT;
            end
         end
         s5hs_pkg::PH_NLEN: begin
            name_len = b;
            byte_idx = '0;
            if (b == 8'd0) parse_phase = s5hs_pkg::PH_NPORT;
            else parse_phase = s5hs_pkg::PH_NAME;
         end
         s5hs_pkg::PH_NAME: begin
            byte_idx = byte_idx + 8'd1;
            if (byte_idx >= name_len) begin
               byte_idx = '0;
               parse_phase = s5hs_pkg::PH_NPORT;
            end
            res.event_code = s5hs_pkg::EV_NAME_CHAR;
            res.name_char  = b;
            hit = 1'b1;
         end
         s5hs_pkg::PH_IPORT, s5hs_pkg::PH_NPORT: begin
            port_acc = {port_acc[7:0], b};
            byte_idx = byte_idx + 8'd1;
            if (byte_idx >= 8'd2) begin
               byte_idx = '0;
               hit = 1'b1;
               res.dest_port = port_acc;
               if (parse_phase == s5hs_pkg::PH_IPORT) begin
                  res.event_code   = s5hs_pkg::EV_IPV4_DONE;
                  res.ipv4_address = addr_acc;
               end else begin
                  res.event_code  = s5hs_pkg::EV_NAME_DONE;
                  res.name_length = name_len;
               end
               parse_phase = s5hs_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase
      return hit;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch("no event pending, event_code", 0, rsp_data.event_code);
            end else begin
               want = expected_events.pop_front();
               if (rsp_data.event_code != want.event_code)
                  report_mismatch("event_code", want.event_code, rsp_data.event_code);
               if (rsp_data.ipv4_address != want.ipv4_address)
                  report_mismatch("ipv4_address", want.ipv4_address, rsp_data.ipv4_address);
               if (rsp_data.dest_port != want.dest_port)
                  report_mismatch("dest_port", want.dest_port, rsp_data.dest_port);
               if (rsp_data.name_char != want.name_char)
                  report_mismatch("name_char", want.name_char, rsp_data.name_char);
               if (rsp_data.name_length != want.name_length)
                  report_mismatch("name_length", want.name_length, rsp_data.name_length);
            end
         end
         if (req_valid && req_ready) begin
            if (parse_byte(req_data, next_event)) expected_events.push_back(next_event);
         end
      end
      // published with nonblocking so the top always reads settled values
      pending_results <= expected_events.size();
      fail_total      <= mismatches;
   end

endmodule

/* test/tb.sv */
// testbench top for the socks5 handshake parser: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;

   localparam int WatchLimit   = 2000;
   localparam int HoldOffLen   = 300;
   localparam int HoldOffAfter = 60;
   localparam int RandomItems  = 450;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   s5hs_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   s5hs_pkg::rsp_type rsp_data;

   int      fail_total;
   int      pending_results;

   s5hs_pkg::req_type client_bytes[$];

   always #1 clock = ~clock;

   socks5_handshake_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   s5hs_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_total      (fail_total),
      .pending_results (pending_results)
   );

   task automatic push_byte(input logic [7:0] b, input logic start);
      s5hs_pkg::req_type item;
      item.data_byte  = b;
      item.start_conn = start;
      client_bytes.push_back(item);
   endtask

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // one connection: greeting, then a connect request, stopping where the parser would stop
   task automatic add_session();
      int         n_meth;
      int         noauth_pos;
      int         n_name;
      int         r;
      int         first;
      int         cut;
      bit         want_noauth;
      logic [7:0] b;
      first = client_bytes.size();
      b = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : s5hs_pkg::SocksVer;
      push_byte(b, 1'b1);
      if (b == s5hs_pkg::SocksVer) begin
         r = $urandom_range(0, 49);
         if (r == 0) n_meth = 0;
         else if (r == 1) n_meth = $urandom_range(100, 255);
         else n_meth = $urandom_range(1, 6);
         push_byte(8'(n_meth), 1'b0);
         want_noauth = ($urandom_range(0, 4) != 0);
         noauth_pos  = (n_meth > 0) ? $urandom_range(0, n_meth - 1) : 0;
         for (int i = 0; i < n_meth; i++) begin
            if (want_noauth && i == noauth_pos) push_byte(s5hs_pkg::MethNoAuth, 1'b0);
            else if (want_noauth) push_byte(8'($urandom_range(0, 255)), 1'b0);
            else push_byte(8'($urandom_range(1, 255)), 1'b0);
         end
         if (n_meth > 0 && want_noauth) begin
            b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : s5hs_pkg::SocksVer;
            push_byte(b, 1'b0);
            if (b == s5hs_pkg::SocksVer) begin
               b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : s5hs_pkg::CmdConnect;
               push_byte(b, 1'b0);
               if (b == s5hs_pkg::CmdConnect) begin
                  push_byte(8'($urandom_range(0, 255)), 1'b0);
                  r = $urandom_range(0, 19);
                  if (r < 9) b = s5hs_pkg::AtypIpv4;
                  else if (r < 18) b = s5hs_pkg::AtypName;
                  else b = 8'($urandom_range(0, 255));
                  push_byte(b, 1'b0);
                  if (b == s5hs_pkg::AtypIpv4) begin
                     push_random(6);
                  end else if (b == s5hs_pkg::AtypName) begin
                     r = $urandom_range(0, 39);
                     if (r < 4) n_name = 0;
                     else if (r == 4) n_name = $urandom_range(13, 255);
                     else n_name = $urandom_range(1, 12);
                     push_byte(8'(n_name), 1'b0);
                     push_random(n_name + 2);
                  end
               end
            end
         end
      end
      // broken sequence: drop the tail so the next start cuts in mid-parse
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(1, client_bytes.size() - first);
         while (client_bytes.size() > first + cut) void'(client_bytes.pop_back());
      end
      // bytes after the final event must stay silent
      if ($urandom_range(0, 5) == 0) push_random($urandom_range(1, 3));
   endtask

   // watchdog on cycles without any transfer
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WatchLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // receiver: random stalls per result and one long hold-off
   initial begin
      int wait_cycles;
      int rsp_seen;
      bit no_gap;
      rsp_seen = 0;
      no_gap   = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) no_gap = !no_gap;
         wait_cycles = no_gap ? 0 : $urandom_range(0, 13);
         if (rsp_seen == HoldOffAfter) wait_cycles = HoldOffLen;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         rsp_seen++;
      end
   end

   initial begin
      int  gap;
      bit  no_gap;
      no_gap = 1'b0;

      // bad greeting version
      push_byte(8'h04, 1'b1);
      // empty method list
      push_byte(s5hs_pkg::SocksVer, 1'b1);
      push_byte(8'h00, 1'b0);
      // ipv4 connect with all-ones address, port and reserved byte, then a silent byte
      push_byte(s5hs_pkg::SocksVer, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(s5hs_pkg::MethNoAuth, 1'b0);
      push_byte(s5hs_pkg::SocksVer, 1'b0);
      push_byte(s5hs_pkg::CmdConnect, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(s5hs_pkg::AtypIpv4, 1'b0);
      for (int i = 0; i < 6; i++) push_byte(8'hFF, 1'b0);
      push_byte(s5hs_pkg::SocksVer, 1'b0);
      // domain connect with an empty name and port zero
      push_byte(s5hs_pkg::SocksVer, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(s5hs_pkg::MethNoAuth, 1'b0);
      push_byte(s5hs_pkg::SocksVer, 1'b0);
      push_byte(s5hs_pkg::CmdConnect, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(s5hs_pkg::AtypName, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);

      while (client_bytes.size() < RandomItems + 27) begin
         if ($urandom_range(0, 4) == 0) begin
            for (int i = $urandom_range(1, 8); i > 0; i--)
               push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
         end else begin
            add_session();
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < client_bytes.size(); i++) begin
         if ($urandom_range(0, 29) == 0) no_gap = !no_gap;
         gap = no_gap ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= client_bytes[i];
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_total == 0 && pending_results == 0 && !rsp_valid)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* socks5_handshake_parser.f */
sv/s5hs_pkg.sv
sv/s5hs_parser.sv
sv/s5hs_out_buf.sv
sv/socks5_handshake_parser.sv
test/s5hs_result_checker.sv
test/tb.sv
